// ===== rtl/gcdlcm_pkg.sv =====
// gcdlcm_pkg: shared widths, divider request/response types and helpers
// used by the gcd/lcm datapath and its iterative divider; no dependencies
`timescale 1ns / 1ps
`default_nettype none

package gcdlcm_pkg;

  localparam int DATA_W = 32;
  localparam int CNT_W  = $clog2(DATA_W);

  typedef logic [DATA_W-1:0] word_t;

  typedef struct packed {
    logic  start;
    word_t dividend;
    word_t divisor;
  } div_req_t;

  typedef struct packed {
    logic  done;
    word_t quotient;
    word_t remainder;
  } div_rsp_t;

  // magnitude of a two's complement word, read as unsigned
  function automatic word_t mag(input word_t v);
    mag = v[DATA_W-1] ? (~v + word_t'(1)) : v;
  endfunction

  function automatic word_t neg(input word_t v);
    neg = ~v + word_t'(1);
  endfunction

endpackage

`default_nettype wire

// ===== rtl/gcdlcm_divider.sv =====
// gcdlcm_divider: radix-2 restoring unsigned divider, one quotient bit per cycle
// depends on gcdlcm_pkg for the request/response types
`timescale 1ns / 1ps
`default_nettype none

module gcdlcm_divider
  import gcdlcm_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire div_req_t req,
  output div_rsp_t      rsp
);

  word_t              rem;
  word_t              quo;
  word_t              dsr;
  logic [CNT_W-1:0]   cnt;
  logic               busy;
  logic               done;

  logic [DATA_W:0]    shifted;
  logic [DATA_W+1:0]  diff;

  assign shifted = {rem, quo[DATA_W-1]};
  assign diff    = {1'b0, shifted} - {2'b00, dsr};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + CNT_W'(1);
        if (cnt == CNT_W'(DATA_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      rem <= '0;
      quo <= req.dividend;
      dsr <= req.divisor;
    end else if (busy) begin
      if (!diff[DATA_W+1]) begin
        rem <= diff[DATA_W-1:0];
        quo <= {quo[DATA_W-2:0], 1'b1};
      end else begin
        rem <= shifted[DATA_W-1:0];
        quo <= {quo[DATA_W-2:0], 1'b0};
      end
    end
  end

  assign rsp.done      = done;
  assign rsp.quotient  = quo;
  assign rsp.remainder = rem;

endmodule

`default_nettype wire

// ===== rtl/gcd_lcm_unit.sv =====
// gcd_lcm_unit: signed gcd by truncating-remainder euclid, then lcm = (a / gcd) * b
// depends on gcdlcm_pkg and gcdlcm_divider (shared by every remainder and the quotient)
//
//   channel  signals                           direction  request
//   in       in_valid in_stall operand_a/b     input      two signed 32-bit operands
//   out      out_valid out_stall divisor       output     gcd, lcm and undefined flag
//            multiple undefined_flag
//
// one request at a time; each euclid step is one pass of the divider plus the check
// state, the lcm quotient is one more pass, then the multiply state
// rst is synchronous and clears the sequencer and the output valid
// a finished result waits in the output register under out_stall; a new request is
// taken meanwhile and only its own result waits for the register to free up
`timescale 1ns / 1ps
`default_nettype none

module gcd_lcm_unit
  import gcdlcm_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire logic signed [31:0] operand_a,
  input  wire logic signed [31:0] operand_b,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic signed [31:0]      divisor,
  output logic signed [31:0]      multiple,
  output logic                    undefined_flag
);

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_CHECK  = 3'd1;
  localparam logic [2:0] ST_REM    = 3'd2;
  localparam logic [2:0] ST_QUOT   = 3'd3;
  localparam logic [2:0] ST_MUL    = 3'd4;
  localparam logic [2:0] ST_FINISH = 3'd5;

  logic [2:0]     state;
  word_t          x;
  word_t          y;
  word_t          a_hold;
  word_t          b_hold;
  word_t          quot;
  word_t          lcm;
  logic           flag;
  div_req_t       div_req;
  div_rsp_t       div_rsp;
  word_t          prod;

  gcdlcm_divider u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  assign in_stall = (state != ST_IDLE);
  assign prod     = quot * b_hold;

  always_comb begin
    div_req.start    = 1'b0;
    div_req.dividend = mag(x);
    div_req.divisor  = mag(y);
    if (state == ST_CHECK) begin
      if (y != '0) begin
        div_req.start = 1'b1;
      end else if (x != '0) begin
        div_req.start    = 1'b1;
        div_req.dividend = mag(a_hold);
        div_req.divisor  = mag(x);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && !out_stall && (state != ST_FINISH)) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (in_valid) begin
            state <= ST_CHECK;
          end
        end
        ST_CHECK: begin
          if (y != '0) begin
            state <= ST_REM;
          end else if (x != '0) begin
            state <= ST_QUOT;
          end else begin
            state <= ST_FINISH;
          end
        end
        ST_REM: begin
          if (div_rsp.done) begin
            state <= ST_CHECK;
          end
        end
        ST_QUOT: begin
          if (div_rsp.done) begin
            state <= ST_MUL;
          end
        end
        ST_MUL: begin
          state <= ST_FINISH;
        end
        ST_FINISH: begin
          if (!out_valid || !out_stall) begin
            out_valid <= 1'b1;
            state     <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        if (in_valid) begin
          x      <= operand_a;
          y      <= operand_b;
          a_hold <= operand_a;
          b_hold <= operand_b;
          flag   <= 1'b0;
        end
      end
      ST_CHECK: begin
        if ((y == '0) && (x == '0)) begin
          flag <= 1'b1;
          lcm  <= '0;
        end
      end
      ST_REM: begin
        if (div_rsp.done) begin
          x <= y;
          y <= x[DATA_W-1] ? neg(div_rsp.remainder) : div_rsp.remainder;
        end
      end
      ST_QUOT: begin
        if (div_rsp.done) begin
          quot <= (a_hold[DATA_W-1] ^ x[DATA_W-1]) ? neg(div_rsp.quotient)
                                                   : div_rsp.quotient;
        end
      end
      ST_MUL: begin
        lcm <= prod;
      end
      ST_FINISH: begin
        if (!out_valid || !out_stall) begin
          divisor        <= x;
          multiple       <= lcm;
          undefined_flag <= flag;
        end
      end
      default: begin
      end
    endcase
  end

  // divider finishes only while the sequencer waits on it
  assert property (@(posedge clk) disable iff (rst)
    div_rsp.done |-> (state == ST_REM || state == ST_QUOT))
    else $error("divider done outside a wait state");

  // a new result is loaded only from the finish state
  assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state) == ST_FINISH)
    else $error("result loaded outside finish");

  // undefined lcm comes with zero gcd and zero lcm
  assert property (@(posedge clk) disable iff (rst)
    (out_valid && undefined_flag) |-> (divisor == '0 && multiple == '0))
    else $error("undefined flag with nonzero result");

  // the divider is never started with a zero divisor
  assert property (@(posedge clk) disable iff (rst)
    div_req.start |-> (div_req.divisor != '0))
    else $error("divider started with zero divisor");

endmodule

`default_nettype wire

// ===== sim/gcd_lcm_checker.sv =====
// gcd_lcm_checker: watches both channels of gcd_lcm_unit, predicts gcd, lcm and the
// undefined flag for each accepted request and compares them with the results in order
// depends on gcdlcm_pkg for the word type
`timescale 1ns / 1ps

module gcd_lcm_checker
  import gcdlcm_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  input  wire logic               in_stall,
  input  wire logic signed [31:0] operand_a,
  input  wire logic signed [31:0] operand_b,
  input  wire logic               out_valid,
  input  wire logic               out_stall,
  input  wire logic signed [31:0] divisor,
  input  wire logic signed [31:0] multiple,
  input  wire logic               undefined_flag,
  output int                      mismatches,
  output int                      outstanding
);

  typedef struct packed {
    word_t gcd;
    word_t lcm;
    logic  undefined;
  } gcd_lcm_t;

  gcd_lcm_t expected_q[$];
  int       fail_count = 0;

  assign mismatches = fail_count;

  function automatic word_t magnitude(input word_t v);
    return v[DATA_W-1] ? word_t'(0) - v : v;
  endfunction

  // truncating remainder, sign follows the dividend
  function automatic word_t trunc_rem(input word_t x, input word_t y);
    word_t r;
    r = magnitude(x) % magnitude(y);
    return x[DATA_W-1] ? word_t'(0) - r : r;
  endfunction

  // truncating quotient, wraps on most negative by -1
  function automatic word_t trunc_quot(input word_t x, input word_t y);
    word_t q;
    q = magnitude(x) / magnitude(y);
    return (x[DATA_W-1] ^ y[DATA_W-1]) ? word_t'(0) - q : q;
  endfunction

  function automatic gcd_lcm_t gcd_lcm(input word_t a, input word_t b);
    gcd_lcm_t res;
    word_t    x;
    word_t    y;
    word_t    t;
    x = a;
    y = b;
    while (y != '0) begin
      t = trunc_rem(x, y);
      x = y;
      y = t;
    end
    res.gcd       = x;
    res.undefined = (x == '0);
    res.lcm       = (x == '0) ? word_t'(0) : word_t'(trunc_quot(a, x) * b);
    return res;
  endfunction

  task automatic check_field(input string name, input word_t want, input word_t got);
    if (want !== got) begin
      $error("%s: expected %0d (0x%08h), got %0d (0x%08h)", name, $signed(want), want,
             $signed(got), got);
      fail_count++;
    end
  endtask

  always @(posedge clk) begin
    gcd_lcm_t want;
    if (!rst) begin
      if (out_valid && !out_stall) begin
        if (expected_q.size() == 0) begin
          $error("result with no request waiting: divisor %0d multiple %0d flag %0b",
                 divisor, multiple, undefined_flag);
          fail_count++;
        end else begin
          want = expected_q.pop_front();
          check_field("divisor", want.gcd, divisor);
          check_field("multiple", want.lcm, multiple);
          check_field("undefined_flag", word_t'(want.undefined), word_t'(undefined_flag));
        end
      end
      if (in_valid && !in_stall)
        expected_q.push_back(gcd_lcm(operand_a, operand_b));
      outstanding <= expected_q.size();
    end
  end

endmodule

// ===== sim/gcd_lcm_unit_test.sv =====
// gcd_lcm_unit_test: drives directed and random operand pairs into gcd_lcm_unit under
// several idle and stall mixes and reports the verdict from gcd_lcm_checker
// depends on gcdlcm_pkg, gcd_lcm_unit and gcd_lcm_checker
`timescale 1ns / 1ps

module gcd_lcm_unit_test
  import gcdlcm_pkg::*;
();

  localparam word_t MOST_NEG    = 32'h8000_0000;
  localparam word_t MOST_POS    = 32'h7FFF_FFFF;
  localparam word_t NEG_ONE     = 32'hFFFF_FFFF;
  localparam int    RANDOM_RUN  = 125;
  localparam int    DRAIN_WAIT  = 1700;
  localparam int    CYCLE_LIMIT = 4_000_000;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic signed [31:0] operand_a = '0;
  logic signed [31:0] operand_b = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic signed [31:0] divisor;
  logic signed [31:0] multiple;
  logic               undefined_flag;
  int                 mismatches;
  int                 outstanding;
  int                 idle_pct = 0;
  int                 stall_pct = 0;
  int                 cycle_count = 0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  gcd_lcm_unit dut (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .operand_a      (operand_a),
    .operand_b      (operand_b),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .divisor        (divisor),
    .multiple       (multiple),
    .undefined_flag (undefined_flag)
  );

  gcd_lcm_checker results_check (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .operand_a      (operand_a),
    .operand_b      (operand_b),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .divisor        (divisor),
    .multiple       (multiple),
    .undefined_flag (undefined_flag),
    .mismatches     (mismatches),
    .outstanding    (outstanding)
  );

  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      out_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("gcd_lcm_unit: mismatch");
      $finish;
    end
  end

  task automatic send_request(input word_t a, input word_t b);
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid  <= 1'b1;
    operand_a <= a;
    operand_b <= b;
    do @(posedge clk); while (in_stall);
  endtask

  function automatic word_t extreme_value();
    case ($urandom_range(5))
      0:       return MOST_NEG;
      1:       return MOST_POS;
      2:       return NEG_ONE;
      3:       return word_t'(0);
      4:       return word_t'(1);
      default: return word_t'($urandom);
    endcase
  endfunction

  task automatic random_request();
    word_t       a;
    word_t       b;
    word_t       g;
    word_t       t;
    int unsigned pick;
    int unsigned n;
    pick = $urandom_range(99);
    if (pick < 30) begin
      a = $urandom;
      b = $urandom;
    end else if (pick < 55) begin
      // shared factor, so the gcd is not trivial
      g = $urandom_range(65536, 1);
      a = g * $urandom_range(3000);
      b = g * $urandom_range(3000);
    end else if (pick < 70) begin
      a = word_t'($urandom_range(200)) - word_t'(100);
      b = word_t'($urandom_range(200)) - word_t'(100);
    end else if (pick < 80) begin
      a = $urandom_range(3) == 0 ? word_t'(0) : word_t'($urandom);
      b = word_t'(0);
      if ($urandom_range(1)) begin
        t = a;
        a = b;
        b = t;
      end
    end else if (pick < 90) begin
      a = extreme_value();
      b = extreme_value();
    end else begin
      // consecutive fibonacci numbers give the longest euclid runs
      n = $urandom_range(46, 2);
      a = 1;
      b = 1;
      repeat (n - 2) begin
        t = a + b;
        b = a;
        a = t;
      end
      if ($urandom_range(1)) begin
        t = a;
        a = b;
        b = t;
      end
    end
    if ($urandom_range(3) == 0) a = word_t'(0) - a;
    if ($urandom_range(3) == 0) b = word_t'(0) - b;
    send_request(a, b);
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // directed requests
    send_request(0, 0);
    send_request(0, 12);
    send_request(-12, 0);
    send_request(MOST_NEG, 0);
    send_request(0, MOST_POS);
    send_request(MOST_NEG, NEG_ONE);
    send_request(NEG_ONE, MOST_NEG);
    send_request(MOST_NEG, MOST_NEG);
    send_request(MOST_POS, MOST_POS);
    send_request(MOST_NEG, MOST_POS);
    send_request(MOST_POS, MOST_NEG);
    send_request(NEG_ONE, NEG_ONE);
    send_request(1, 1);
    send_request(MOST_NEG, 1);
    send_request(12, 18);
    send_request(-12, 18);
    send_request(12, -18);
    send_request(-12, -18);
    send_request(65536, 65537);
    send_request(MOST_POS, 2);
    send_request(1836311903, 1134903170);
    send_request(-1836311903, 1134903170);
    send_request(1134903170, -1836311903);
    send_request(32'h5555_5555, 32'hAAAA_AAAA);

    // random phases: no idling, sender idle, receiver stalling, both
    repeat (RANDOM_RUN) random_request();
    idle_pct  = 82;
    stall_pct = 0;
    repeat (RANDOM_RUN) random_request();
    idle_pct  = 0;
    stall_pct = 82;
    repeat (RANDOM_RUN) random_request();
    idle_pct  = 22;
    stall_pct = 22;
    repeat (RANDOM_RUN) random_request();

    in_valid  <= 1'b0;
    stall_pct = 0;
    do @(posedge clk); while (outstanding != 0);
    repeat (DRAIN_WAIT) @(posedge clk);

    if (mismatches == 0) begin
      $display("gcd_lcm_unit: match");
    end else begin
      $display("gcd_lcm_unit: mismatch");
    end
    $finish;
  end

endmodule
